// ----- hdl/rth_pkg.sv -----
package rth_pkg;

	localparam int unsigned NUM_CELLS = 12;
	localparam int unsigned QW        = NUM_CELLS;
	localparam int unsigned NW        = 20;
	localparam int unsigned DW        = NW - 1;

	localparam logic [11:0] SLOPE_Q6     = 12'd2730;
	localparam logic [15:0] OFF_RED_Q6   = 16'd0;
	localparam logic [15:0] OFF_GREEN_Q6 = 16'd5461;
	localparam logic [15:0] OFF_BLUE_Q6  = 16'd10923;

	localparam logic [1:0] SEC_RED   = 2'd0;
	localparam logic [1:0] SEC_GREEN = 2'd1;
	localparam logic [1:0] SEC_BLUE  = 2'd2;

	typedef struct packed {
		logic [NW-1:0] hrem;
		logic [DW-1:0] hden;
		logic [QW-1:0] hq;
		logic [NW-1:0] srem;
		logic [DW-1:0] sden;
		logic [QW-1:0] sq;
		logic          neg;
		logic [1:0]    sector;
		logic [7:0]    bright;
	} rth_word_t;

endpackage

// ----- hdl/rgb_to_hsv_8bit.sv -----
// RGB to HSV converter, 8 bits per channel, hue on a 0..255 circle.
// Input: s_tvalid/s_tready/s_tdata, one pixel per transfer
//   (red [7:0], green [15:8], blue [23:16]).
// Output: m_tvalid/m_tready/m_tdata, one result per pixel, same order
//   (hue [7:0], saturation [15:8], brightness [23:16]).
// The pipeline is one front stage (max/min, sector, constant
// multiplies), a chain of 12 divider cells that each resolve one quotient
// bit of both the hue and the saturation division, and the output register.
// Throughput is one pixel per cycle while m_tready keeps the output moving; every
// stage is elastic, so bubbles close up and s_tready stays high while any stage has room.
// When the receiver stalls, the result holds on m_tdata and the chain fills;
// s_tready drops only once all 14 stages hold a pixel.
// Asynchronous reset (arst_n low) empties every stage; no pixel survives it.
module rgb_to_hsv_8bit import rth_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // red, green, blue
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // hue, saturation, brightness
);

	logic      cv [NUM_CELLS+1];
	logic      cr [NUM_CELLS+1];
	rth_word_t cd [NUM_CELLS+1];

	rth_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.red       (s_tdata[7:0]),
		.green     (s_tdata[15:8]),
		.blue      (s_tdata[23:16]),
		.out_valid (cv[0]),
		.out_ready (cr[0]),
		.out_data  (cd[0])
	);

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		rth_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[k]),
			.in_ready  (cr[k]),
			.in_data   (cd[k]),
			.out_valid (cv[k+1]),
			.out_ready (cr[k+1]),
			.out_data  (cd[k+1])
		);
	end

	rth_word_t  last;
	logic [15:0] off;
	logic [12:0] qfix;
	logic [15:0] qext;
	logic [15:0] t;
	logic        valid_q;
	logic [23:0] tdata_q;

	assign last = cd[NUM_CELLS];

	always_comb begin
		unique case (last.sector)
			SEC_RED:   off = OFF_RED_Q6;
			SEC_GREEN: off = OFF_GREEN_Q6;
			SEC_BLUE:  off = OFF_BLUE_Q6;
			default:   off = OFF_RED_Q6;
		endcase
		// floor towards minus infinity for a negative difference
		qfix = {1'b0, last.hq} + 13'((last.neg && last.hrem != '0) ? 1 : 0);
		qext = {3'b0, qfix};
		t    = off + (last.neg ? (~qext + 16'd1) : qext);
	end

	assign cr[NUM_CELLS] = !valid_q || m_tready;
	assign m_tvalid      = valid_q;
	assign m_tdata       = tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cr[NUM_CELLS]) begin
			valid_q <= cv[NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (cv[NUM_CELLS] && cr[NUM_CELLS]) begin
			tdata_q <= {last.bright, last.sq[7:0], t[13:6]};
		end
	end

	a_black_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[23:16] == 8'd0 |-> m_tdata[15:8] == 8'd0)
		else $error("black pixel with non-zero saturation");

	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15:8] == 8'd0 |-> m_tdata[7:0] == 8'd0)
		else $error("grey pixel with non-zero hue");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output stage free");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !cv[NUM_CELLS] |=> !m_tvalid)
		else $error("result repeated after transfer");

endmodule

// ----- hdl/rth_front.sv -----
module rth_front import rth_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      red,
	input  logic [7:0]      green,
	input  logic [7:0]      blue,
	output logic            out_valid,
	input  logic            out_ready,
	output rth_word_t       out_data
);

	logic       valid_q;
	rth_word_t  data_s1;
	rth_word_t  nxt;
	logic [7:0] v;
	logic [7:0] lo;
	logic [8:0] diff;
	logic [7:0] mag;
	logic [7:0] delta;
	logic [1:0] sector;
	logic [7:0] hden8;
	logic [7:0] sden8;

	always_comb begin
		if (red >= green && red >= blue) begin
			v      = red;
			lo     = (green < blue) ? green : blue;
			diff   = {1'b0, green} - {1'b0, blue};
			sector = SEC_RED;
		end else if (green >= blue) begin
			v      = green;
			lo     = (red < blue) ? red : blue;
			diff   = {1'b0, blue} - {1'b0, red};
			sector = SEC_GREEN;
		end else begin
			v      = blue;
			lo     = (red < green) ? red : green;
			diff   = {1'b0, red} - {1'b0, green};
			sector = SEC_BLUE;
		end
		delta = v - lo;
		mag   = diff[8] ? 8'(~diff + 9'd1) : diff[7:0];
		hden8 = (delta == 8'd0) ? 8'd1 : delta;
		sden8 = (v == 8'd0) ? 8'd1 : v;

		nxt.hrem   = NW'(mag) * NW'(SLOPE_Q6);
		nxt.hden   = {hden8, (DW-8)'(0)};
		nxt.hq     = '0;
		nxt.srem   = NW'({delta, 8'd0}) - NW'(delta);
		nxt.sden   = {sden8, (DW-8)'(0)};
		nxt.sq     = '0;
		nxt.neg    = diff[8];
		nxt.sector = sector;
		nxt.bright = v;
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ----- hdl/rth_cell.sv -----
module rth_cell import rth_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  rth_word_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output rth_word_t out_data
);

	// one restoring step for each divider, divisor halves on the way down
	logic      valid_q;
	rth_word_t data_q;
	rth_word_t nxt;
	logic      hge;
	logic      sge;

	always_comb begin
		nxt    = in_data;
		hge    = in_data.hrem >= {1'b0, in_data.hden};
		sge    = in_data.srem >= {1'b0, in_data.sden};
		nxt.hrem = hge ? in_data.hrem - {1'b0, in_data.hden} : in_data.hrem;
		nxt.srem = sge ? in_data.srem - {1'b0, in_data.sden} : in_data.srem;
		nxt.hq   = {in_data.hq[QW-2:0], hge};
		nxt.sq   = {in_data.sq[QW-2:0], sge};
		nxt.hden = in_data.hden >> 1;
		nxt.sden = in_data.sden >> 1;
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

endmodule

// ----- verif/tb_rgb_to_hsv_8bit.sv -----
module tb_rgb_to_hsv_8bit;
	timeunit 1ns;
	timeprecision 1ps;

	import rth_pkg::*;

	localparam int unsigned RANDOM_PIXELS   = 450;
	localparam int unsigned HOLD_CYCLES     = 80;
	localparam int unsigned DRAIN_CYCLES    = 40;
	localparam int unsigned WATCHDOG_CYCLES = 2000;

	class hsv_scoreboard;
		typedef struct {
			logic [23:0] pix;
			logic [7:0]  hue;
			logic [7:0]  sat;
			logic [7:0]  bright;
		} hsv_t;

		hsv_t        hsv_due[$];
		int unsigned errors;
		int unsigned results;
		int unsigned pixels;

		function hsv_t to_hsv(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
			int   r, g, b, v, lo, diff, off, delta, num, q, t;
			hsv_t res;
			r = red;
			g = green;
			b = blue;
			if (r >= g && r >= b) begin
				v    = r;
				lo   = (g < b) ? g : b;
				diff = g - b;
				off  = int'(OFF_RED_Q6);
			end else if (g >= b) begin
				v    = g;
				lo   = (r < b) ? r : b;
				diff = b - r;
				off  = int'(OFF_GREEN_Q6);
			end else begin
				v    = b;
				lo   = (r < g) ? r : g;
				diff = r - g;
				off  = int'(OFF_BLUE_Q6);
			end
			delta = v - lo;
			t     = off;
			if (delta != 0) begin
				num = int'(SLOPE_Q6) * diff;
				// floor towards minus infinity
				if (num >= 0)
					q = num / delta;
				else
					q = -((-num + delta - 1) / delta);
				t += q;
			end
			// bias of 65536, a multiple of 64*256, keeps flooring and wrap intact
			res.pix    = {blue, green, red};
			res.hue    = 8'((t + 65536) >> 6);
			res.sat    = (v == 0) ? 8'd0 : 8'((255 * delta) / v);
			res.bright = 8'(v);
			return res;
		endfunction

		function void note_pixel(logic [23:0] pix);
			hsv_due.push_back(to_hsv(pix[7:0], pix[15:8], pix[23:16]));
			pixels++;
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH @%0t: %s", $time, msg);
		endtask

		task check_result(logic [23:0] word);
			hsv_t want;
			results++;
			if (hsv_due.size() == 0) begin
				report($sformatf("result %h with no pixel outstanding", word));
				return;
			end
			want = hsv_due.pop_front();
			if (word[7:0] !== want.hue)
				report($sformatf("pixel %h hue %0d, want %0d", want.pix, word[7:0], want.hue));
			if (word[15:8] !== want.sat)
				report($sformatf("pixel %h saturation %0d, want %0d", want.pix, word[15:8],
					want.sat));
			if (word[23:16] !== want.bright)
				report($sformatf("pixel %h brightness %0d, want %0d", want.pix, word[23:16],
					want.bright));
		endtask
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;  // red, green, blue
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // hue, saturation, brightness

	hsv_scoreboard sb = new();

	bit tx_idle  = 1'b1;
	bit rx_idle  = 1'b1;
	bit hold_req = 1'b0;

	rgb_to_hsv_8bit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	task automatic send_pixel(input logic [23:0] pix);
		if (tx_idle && $urandom_range(99) < 33) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while (tx_idle && $urandom_range(99) < 33);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_pixel(pix);
	endtask

	function automatic logic [7:0] near(logic [7:0] base);
		int t;
		t = int'(base) + int'($urandom_range(6)) - 3;
		if (t < 0)
			t = 0;
		if (t > 255)
			t = 255;
		return 8'(t);
	endfunction

	// random, with grey-ish pixels, ties, extreme and near-black channels mixed in
	function automatic logic [23:0] random_pixel();
		logic [7:0] a, b, c;
		logic [7:0] edges [4];
		edges = '{8'd0, 8'd1, 8'd254, 8'd255};
		a = 8'($urandom);
		b = 8'($urandom);
		c = 8'($urandom);
		case ($urandom_range(9)) inside
			4, 5: begin
				return {near(a), near(a), near(a)};
			end
			6, 7: begin
				case ($urandom_range(3))
					0: return {b, a, a};
					1: return {a, b, a};
					2: return {a, a, b};
					default: return {a, a, a};
				endcase
			end
			8: begin
				return {edges[$urandom_range(3)], edges[$urandom_range(3)],
					edges[$urandom_range(3)]};
			end
			9: begin
				return {8'($urandom_range(3)), 8'($urandom_range(3)), 8'($urandom_range(3))};
			end
			default: begin
				return {c, b, a};
			end
		endcase
	endfunction

	// blue, green, red
	logic [23:0] directed [] = '{
		24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFEFEFE,
		24'h0000FF, 24'h00FF00, 24'hFF0000,
		24'h00FFFF, 24'hFFFF00, 24'hFF00FF,
		24'h0100FF, 24'hFE00FF, 24'h0001FF,
		24'h01FF00, 24'h00FFFE, 24'hFFFE00, 24'hFF0001,
		24'h000001, 24'h000100, 24'h010000,
		24'h7F807F, 24'h55AAFF, 24'hAA5500
	};

	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (hold_req) begin
				hold_req = 1'b0;
				hold     = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !rx_idle || ($urandom_range(99) >= 33);
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transfer for %0d cycles", WATCHDOG_CYCLES);
		$display("rgb_to_hsv_8bit test failed");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_pixel(directed[i]);

		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			if (i == 150) begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end
			if (i == 300) begin
				tx_idle  = 1'b1;
				rx_idle  = 1'b1;
				hold_req = 1'b1;
			end
			send_pixel(random_pixel());
		end
		s_tvalid <= 1'b0;

		while (sb.hsv_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d pixels sent (extremes, ties, grey, hue wrap, random mix), %0d results checked",
			sb.pixels, sb.results);
		$display("random gaps on both sides, one idle-free stretch, one long output stall");
		if (sb.errors == 0 && sb.hsv_due.size() == 0) begin
			$display("rgb_to_hsv_8bit test passed");
		end else begin
			$display("%0d mismatches, %0d results outstanding", sb.errors, sb.hsv_due.size());
			$display("rgb_to_hsv_8bit test failed");
		end
		$finish;
	end

endmodule
